// ----- rtl/bfbp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfbp_pkg
// shared constants for the best-fit bin packer
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int unsigned MaxBinsDefault = 1024;

  localparam int unsigned WeightW   = 32;
  localparam int unsigned IndexOutW = 10;
  localparam int unsigned CountOutW = 11;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

endpackage

// ----- rtl/bfbp_load_mem.sv -----
// ----------------------------------------------------------------------------
// bfbp_load_mem
// single-port load table with one shared address, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bfbp_load_mem #(
  parameter int unsigned Depth = bfbp_pkg::MaxBinsDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic                         re_i,
  input  logic [AddrW-1:0]             addr_i,
  input  logic [bfbp_pkg::WeightW-1:0] wdata_i,
  output logic [bfbp_pkg::WeightW-1:0] rdata_o
);
  import bfbp_pkg::*;

  logic [WeightW-1:0] mem_q [Depth];
  logic [WeightW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/best_fit_bin_packer.sv -----
// ----------------------------------------------------------------------------
// best_fit_bin_packer
// online best-fit bin packing over a load table held in a synchronous memory
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tuser
// s_axis    in   [31:0] item_weight                      [0] start_new_set
// m_axis    out  [9:0] bin_index, [10] opened_new,       -
//                [21:11] bins_in_use, [22] table_full
// cfg       in   cfg_wdata_i = bin_capacity, written when cfg_we_i
//
// an item is taken in idle, then the scan covers its n open bins, up to MAX_BINS,
// and decide registers its result in the output register
// the scan reads one bin load per cycle from the single memory port
// reset clears the bin count and capacity; table contents are not cleared
// a finished item waits in the output register while the next one is taken
// the decide cycle stalls while the output register holds an untaken item
// ----------------------------------------------------------------------------
module best_fit_bin_packer #(
  parameter int unsigned MAX_BINS = bfbp_pkg::MaxBinsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfbp_pkg::WeightW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bfbp_pkg::InDataW-1:0]  s_axis_tdata,  // [31:0] item_weight
  input  logic                          s_axis_tuser,  // [0] start_new_set
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [9:0] bin_index, [10] opened_new, [21:11] bins_in_use, [22] table_full
  output logic [bfbp_pkg::OutDataW-1:0] m_axis_tdata
);
  import bfbp_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BINS);
  localparam int unsigned CntW = $clog2(MAX_BINS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BINS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [WeightW-1:0] cap_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    rd_ptr_q, rd_ptr_d;
  logic               rvalid_q, rvalid_d;
  logic [IdxW-1:0]    rtag_q, rtag_d;
  logic               found_q, found_d;
  logic [WeightW-1:0] best_q, best_d;
  logic [IdxW-1:0]    pick_q, pick_d;
  logic [WeightW-1:0] weight_q, weight_d;
  logic               out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic               in_accept;
  logic               out_free;
  logic               rd_issue;
  logic               mem_we;
  logic [IdxW-1:0]    mem_addr;
  logic [WeightW-1:0] mem_wdata;
  logic [WeightW-1:0] mem_rdata;
  logic [WeightW:0]   fit_sum;
  logic               fits;
  logic [31:0]        idx_wide;
  logic [31:0]        cnt_wide;
  logic [IdxW-1:0]    res_idx;
  logic               res_open;
  logic               res_full;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign rd_issue      = (state_q == S_SCAN) && (rd_ptr_q < cnt_q);

  assign fit_sum = {1'b0, mem_rdata} + {1'b0, weight_q};
  assign fits    = (fit_sum <= {1'b0, cap_q}) && (!found_q || (mem_rdata > best_q));

  bfbp_load_mem #(
    .Depth (MAX_BINS),
    .AddrW (IdxW)
  ) u_load_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (rd_issue),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    rvalid_d    = rd_issue;
    rtag_d      = rd_ptr_q[IdxW-1:0];
    found_d     = found_q;
    best_d      = best_q;
    pick_d      = pick_q;
    weight_d    = weight_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_addr    = rd_ptr_q[IdxW-1:0];
    mem_wdata   = weight_q;
    res_idx     = '0;
    res_open    = 1'b0;
    res_full    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          weight_d = s_axis_tdata[WeightW-1:0];
          rd_ptr_d = '0;
          found_d  = 1'b0;
          if (s_axis_tuser) begin
            cnt_d = '0;
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_issue) begin
          rd_ptr_d = rd_ptr_q + CntW'(1);
        end
        if (rvalid_q && fits) begin
          found_d = 1'b1;
          best_d  = mem_rdata;
          pick_d  = rtag_q;
        end
        if (!rd_issue && !rvalid_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (found_q) begin
          res_idx   = pick_q;
          mem_addr  = pick_q;
          mem_wdata = best_q + weight_q;
        end else if (cnt_q < MaxCnt) begin
          res_idx   = cnt_q[IdxW-1:0];
          res_open  = 1'b1;
          mem_addr  = cnt_q[IdxW-1:0];
          mem_wdata = weight_q;
        end else begin
          res_full = 1'b1;
        end
        if (out_free) begin
          mem_we      = !res_full;
          if (res_open) begin
            cnt_d = cnt_q + CntW'(1);
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    idx_wide = 32'(res_idx);
    cnt_wide = 32'(cnt_d);
    if (state_q == S_DECIDE && out_free) begin
      out_data_d = {1'b0, res_full, cnt_wide[CountOutW-1:0], res_open,
                    idx_wide[IndexOutW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= '0;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cnt_q       <= cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      rvalid_q    <= rvalid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rtag_q     <= rtag_d;
    best_q     <= best_d;
    pick_q     <= pick_d;
    weight_q   <= weight_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("bin count above table size");

  a_rvalid_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == S_SCAN))
    else $error("read data returned outside scan");

  a_pick_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && found_q) |-> ({1'b0, 32'(pick_q)} < {1'b0, 32'(cnt_q)}))
    else $error("chosen bin is not open");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_SCAN))
    else $error("accepted item did not start scan");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_DECIDE && !rd_issue))
    else $error("table write outside decide");
`endif

endmodule
